// ===== rtl/core/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// SD SPI sequencer package
// Shared types and constants for the SD card SPI-mode command sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int BlockBytes = 512;
  localparam int IdxW = $clog2(BlockBytes + 1);

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_XFER  = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE, PH_READY, PH_FRAME, PH_RESP, PH_IDLE_DUMMY, PH_TOKEN,
    PH_RDATA, PH_RCRC, PH_WGAP, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP,
    PH_BUSY, PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_READY_POLL = 3'd0,
    REG_RESP_POLL  = 3'd1,
    REG_IDLE_EXIT  = 3'd2,
    REG_TOKEN_POLL = 3'd3,
    REG_WAKEUP     = 3'd4
  } reg_idx_t;

  localparam logic [7:0] CmdIdle   = 8'h40;
  localparam logic [7:0] CmdOpcond = 8'h41;
  localparam logic [7:0] CmdRead   = 8'h51;
  localparam logic [7:0] CmdWrite  = 8'h58;
  localparam logic [7:0] ByteFill  = 8'hFF;
  localparam logic [7:0] ByteToken = 8'hFE;
  localparam logic [7:0] CrcIdle   = 8'h95;
  localparam logic [7:0] RespMask  = 8'h1F;
  localparam logic [7:0] RespOk    = 8'h05;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_address;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       exchange_request;
    logic       chip_select_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       write_byte_taken;
    logic       done_res;
    logic       status;
  } result_t;

  typedef struct packed {
    logic [15:0] ready_poll_limit;
    logic [7:0]  response_poll_limit;
    logic [15:0] idle_exit_limit;
    logic [15:0] token_poll_limit;
    logic [7:0]  wakeup_byte_count;
  } cfg_t;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

// ===== rtl/core/sdspi_if.sv =====
// ----------------------------------------------------------------------------
// SD SPI stream interfaces
// Valid/ready channels for sequencer items and results.
// ----------------------------------------------------------------------------
interface sdspi_in_if;
  import sdspi_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] block_address;
  logic [7:0]  miso_byte;
  logic [7:0]  write_byte;
  modport source (output valid, action, block_address, miso_byte, write_byte,
                  input ready);
  modport sink (input valid, action, block_address, miso_byte, write_byte,
                output ready);
endinterface

interface sdspi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mosi_byte;
  logic       exchange_request;
  logic       chip_select_low;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       write_byte_taken;
  logic       done_res;
  logic       status;
  modport source (output valid, mosi_byte, exchange_request, chip_select_low,
                  read_byte, read_valid, write_byte_taken, done_res, status,
                  input ready);
  modport sink (input valid, mosi_byte, exchange_request, chip_select_low,
                read_byte, read_valid, write_byte_taken, done_res, status,
                output ready);
endinterface

// ===== rtl/core/sdspi_front.sv =====
// ----------------------------------------------------------------------------
// SD SPI front end
// Accepts items and pushes them into a short queue.
// ----------------------------------------------------------------------------
module sdspi_front
  import sdspi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  localparam int Depth = 2;

  item_t      mem [Depth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(Depth))
    else $error("front queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("front queue count lost a push");
  assert property (@(posedge clk) disable iff (rst) count == 2'd0 |-> !pop)
    else $error("pop from empty queue");

endmodule

// ===== rtl/core/sdspi_back.sv =====
// ----------------------------------------------------------------------------
// SD SPI back end
// Runs the card sequence one item per cycle, while the result stage is not stalled, into a registered result stage.
// ----------------------------------------------------------------------------
module sdspi_back
  import sdspi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  output logic    q_ready,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  phase_t      phase, phase_next;
  op_t         operation, operation_next;
  logic [IdxW-1:0] byte_index, byte_index_next;
  logic [15:0] poll_count, poll_count_next;
  logic [15:0] attempt_count, attempt_count_next;
  logic [31:0] saved_address, saved_address_next;
  logic [7:0]  current_command, current_command_next;
  logic        select_level, select_level_next;
  result_t     res;
  logic        fire;
  logic [15:0] poll_inc;
  logic [15:0] att_inc;
  logic [IdxW-1:0] idx_inc;
  logic [7:0]  miso;
  logic [7:0]  frame;

  assign q_ready = !out_valid || out_ready;
  assign fire    = q_valid && q_ready;
  assign miso    = q_item.miso_byte;
  assign poll_inc = poll_count + 16'd1;
  assign att_inc  = attempt_count + 16'd1;
  assign idx_inc  = byte_index + IdxW'(1);

  // Frame byte selected by the incremented index.
  always_comb begin
    unique case (idx_inc)
      IdxW'(1): frame = saved_address[31:24];
      IdxW'(2): frame = saved_address[23:16];
      IdxW'(3): frame = saved_address[15:8];
      IdxW'(4): frame = saved_address[7:0];
      default:  frame = (current_command == CmdIdle) ? CrcIdle : ByteFill;
    endcase
  end

  always_comb begin
    phase_next           = phase;
    operation_next       = operation;
    byte_index_next      = byte_index;
    poll_count_next      = poll_count;
    attempt_count_next   = attempt_count;
    saved_address_next   = saved_address;
    current_command_next = current_command;
    select_level_next    = select_level;
    res                  = '0;
    res.mosi_byte        = ByteFill;
    priority case (action_t'(q_item.action))
      ACT_INIT: begin
        operation_next     = OP_INIT;
        saved_address_next = '0;
        select_level_next  = 1'b0;
        phase_next         = PH_WAKE;
        byte_index_next    = '0;
        res.exchange_request = 1'b1;
      end
      ACT_READ, ACT_WRITE: begin
        operation_next = (q_item.action == ACT_READ) ? OP_READ : OP_WRITE;
        saved_address_next   = q_item.block_address;
        current_command_next = (q_item.action == ACT_READ) ? CmdRead : CmdWrite;
        poll_count_next      = '0;
        phase_next           = PH_READY;
        res.exchange_request = 1'b1;
      end
      default: begin
        res.exchange_request = 1'b1;
        unique case (phase)
          PH_WAKE: begin
            byte_index_next = idx_inc;
            if (16'(idx_inc) >= at_least_one({8'd0, cfg.wakeup_byte_count})) begin
              current_command_next = CmdIdle;
              poll_count_next      = '0;
              phase_next           = PH_READY;
            end
          end
          PH_READY: begin
            poll_count_next = poll_inc;
            if (miso == ByteFill || poll_inc >= at_least_one(cfg.ready_poll_limit)) begin
              select_level_next = 1'b1;
              phase_next        = PH_FRAME;
              byte_index_next   = '0;
              res.mosi_byte     = current_command;
            end
          end
          PH_FRAME: begin
            byte_index_next = idx_inc;
            if (idx_inc < IdxW'(6)) begin
              res.mosi_byte = frame;
            end else begin
              phase_next      = PH_RESP;
              poll_count_next = '0;
            end
          end
          PH_RESP: begin
            poll_count_next = poll_inc;
            if (!miso[7] || poll_inc >= at_least_one({8'd0, cfg.response_poll_limit}))
            begin
              if (operation == OP_INIT) begin
                if (current_command == CmdIdle) begin
                  if (miso != 8'h01) begin
                    phase_next = PH_IDLE;
                    select_level_next = 1'b0;
                    res.exchange_request = 1'b0;
                    res.done_res = 1'b1;
                    res.status = 1'b1;
                  end else begin
                    attempt_count_next = '0;
                    phase_next = PH_IDLE_DUMMY;
                  end
                end else begin
                  attempt_count_next = att_inc;
                  if (miso == 8'd0 || att_inc >= at_least_one(cfg.idle_exit_limit)) begin
                    select_level_next = 1'b0;
                    phase_next = PH_TAIL;
                  end else begin
                    phase_next = PH_IDLE_DUMMY;
                  end
                end
              end else if (miso != 8'd0) begin
                phase_next = PH_IDLE;
                select_level_next = 1'b0;
                res.exchange_request = 1'b0;
                res.done_res = 1'b1;
                res.status = 1'b1;
              end else if (operation == OP_READ) begin
                poll_count_next = '0;
                phase_next = PH_TOKEN;
              end else begin
                phase_next = PH_WGAP;
              end
            end
          end
          PH_IDLE_DUMMY: begin
            current_command_next = CmdOpcond;
            poll_count_next      = '0;
            phase_next           = PH_READY;
          end
          PH_TOKEN: begin
            poll_count_next = poll_inc;
            if (miso == ByteToken || poll_inc >= at_least_one(cfg.token_poll_limit)) begin
              phase_next      = PH_RDATA;
              byte_index_next = '0;
            end
          end
          PH_RDATA: begin
            res.read_byte   = miso;
            res.read_valid  = 1'b1;
            byte_index_next = idx_inc;
            if (idx_inc >= IdxW'(BlockBytes)) begin
              phase_next      = PH_RCRC;
              byte_index_next = '0;
            end
          end
          PH_RCRC: begin
            byte_index_next = idx_inc;
            if (idx_inc >= IdxW'(2)) begin
              select_level_next = 1'b0;
              phase_next = PH_TAIL;
            end
          end
          PH_WGAP: begin
            phase_next    = PH_WTOKEN;
            res.mosi_byte = ByteToken;
          end
          PH_WTOKEN: begin
            phase_next           = PH_WDATA;
            byte_index_next      = '0;
            res.mosi_byte        = q_item.write_byte;
            res.write_byte_taken = 1'b1;
          end
          PH_WDATA: begin
            byte_index_next = idx_inc;
            if (idx_inc < IdxW'(BlockBytes)) begin
              res.mosi_byte        = q_item.write_byte;
              res.write_byte_taken = 1'b1;
            end else begin
              phase_next      = PH_WCRC;
              byte_index_next = '0;
            end
          end
          PH_WCRC: begin
            byte_index_next = idx_inc;
            if (idx_inc >= IdxW'(2)) begin
              phase_next = PH_WRESP;
            end
          end
          PH_WRESP: begin
            if ((miso & RespMask) != RespOk) begin
              phase_next = PH_IDLE;
              select_level_next = 1'b0;
              res.exchange_request = 1'b0;
              res.done_res = 1'b1;
              res.status = 1'b1;
            end else begin
              phase_next = PH_BUSY;
            end
          end
          PH_BUSY: begin
            if (miso != 8'd0) begin
              select_level_next = 1'b0;
              phase_next = PH_TAIL;
            end
          end
          PH_TAIL: begin
            phase_next = PH_IDLE;
            select_level_next = 1'b0;
            res.exchange_request = 1'b0;
            res.done_res = 1'b1;
          end
          default: begin
            res.exchange_request = 1'b0;
          end
        endcase
      end
    endcase
    res.chip_select_low = select_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      operation       <= OP_INIT;
      byte_index      <= '0;
      poll_count      <= '0;
      attempt_count   <= '0;
      saved_address   <= '0;
      current_command <= '0;
      select_level    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (fire) begin
        phase           <= phase_next;
        operation       <= operation_next;
        byte_index      <= byte_index_next;
        poll_count      <= poll_count_next;
        attempt_count   <= attempt_count_next;
        saved_address   <= saved_address_next;
        current_command <= current_command_next;
        select_level    <= select_level_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted item produced no result");
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !select_level)
    else $error("select held while idle");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.done_res |-> !out_res.exchange_request)
    else $error("done result also requests an exchange");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.write_byte_taken |-> !out_res.read_valid)
    else $error("read and write data in one result");

endmodule

// ===== rtl/core/sdspi_regs.sv =====
// ----------------------------------------------------------------------------
// SD SPI configuration registers
// APB-style register file holding the poll limits and wakeup count.
// ----------------------------------------------------------------------------
module sdspi_regs
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_poll_limit    <= 16'd50000;
      cfg.response_poll_limit <= 8'd10;
      cfg.idle_exit_limit     <= 16'd5000;
      cfg.token_poll_limit    <= 16'd10000;
      cfg.wakeup_byte_count   <= 8'd10;
    end else if (wr_en) begin
      unique case (idx)
        REG_READY_POLL: cfg.ready_poll_limit    <= pwdata[15:0];
        REG_RESP_POLL:  cfg.response_poll_limit <= pwdata[7:0];
        REG_IDLE_EXIT:  cfg.idle_exit_limit     <= pwdata[15:0];
        REG_TOKEN_POLL: cfg.token_poll_limit    <= pwdata[15:0];
        REG_WAKEUP:     cfg.wakeup_byte_count   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_READY_POLL: prdata = {16'd0, cfg.ready_poll_limit};
      REG_RESP_POLL:  prdata = {24'd0, cfg.response_poll_limit};
      REG_IDLE_EXIT:  prdata = {16'd0, cfg.idle_exit_limit};
      REG_TOKEN_POLL: prdata = {16'd0, cfg.token_poll_limit};
      REG_WAKEUP:     prdata = {24'd0, cfg.wakeup_byte_count};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/sd_card_spi_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// SD card SPI command sequencer
// Host-side SD SPI sequencer stepped one byte exchange per item.
// ----------------------------------------------------------------------------
// Channel   Role  Payload
// in_ch     sink  action, block_address, miso_byte, write_byte
// out_ch    src   mosi_byte, exchange_request, chip_select_low, read_byte,
//                 read_valid, write_byte_taken, done_res, status
// apb       cfg   five limit registers at 4*i
//
// One item per cycle while results are taken; each item passes through the
// two-entry input queue and the result register. Synchronous reset clears
// state and loads register defaults. A stalled result holds the back end;
// the queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module sd_card_spi_command_sequencer
  import sdspi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sdspi_in_if.sink      in_ch,
  sdspi_out_if.source   out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  assign in_item.action        = in_ch.action;
  assign in_item.block_address = in_ch.block_address;
  assign in_item.miso_byte     = in_ch.miso_byte;
  assign in_item.write_byte    = in_ch.write_byte;

  sdspi_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  sdspi_front u_front (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item,
    .q_valid, .q_ready, .q_item
  );

  sdspi_back u_back (
    .clk, .rst, .cfg,
    .q_valid, .q_ready, .q_item,
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.mosi_byte        = res.mosi_byte;
  assign out_ch.exchange_request = res.exchange_request;
  assign out_ch.chip_select_low  = res.chip_select_low;
  assign out_ch.read_byte        = res.read_byte;
  assign out_ch.read_valid       = res.read_valid;
  assign out_ch.write_byte_taken = res.write_byte_taken;
  assign out_ch.done_res         = res.done_res;
  assign out_ch.status           = res.status;

endmodule

// ===== dv/tb_sd_card_spi_command_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI command sequencer testbench
// Drives request and exchange items through the input channel. A card-side
// responder picks each returned byte from the predicted state, so that init
// and block write sequences run to completion or are cut short on purpose.
// Every result is checked against an in-bench model of the sequencer or a
// directed expected value, under several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_sd_card_spi_command_sequencer;
  import sdspi_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sdspi_in_if  in_ch ();
  sdspi_out_if out_ch ();

  sd_card_spi_command_sequencer u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sequencer state as the bench predicts it.
  cfg_t        lim;
  phase_t      p_ph;
  op_t         p_op;
  int          p_idx;
  int          p_polls;
  logic [15:0] p_rounds;
  logic [31:0] p_addr;
  logic [7:0]  p_cmd;
  logic        p_cs;

  result_t     expected_q[$];
  int          tx_idle;
  int          rx_stall;
  bit          hold_req;
  int          hold_left;
  int          n_sent;
  int          n_bad;
  int          n_rdata;
  int          n_wdata;
  int          n_done;
  int          n_err_ends;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  dir_row_t dir_tab[25];

  function automatic int floor1(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void tx(inout result_t r, input logic [7:0] b);
    r.mosi_byte = b;
    r.exchange_request = 1'b1;
  endfunction

  function automatic void end_op(inout result_t r, input logic err);
    p_ph = PH_IDLE;
    p_cs = 1'b0;
    r.done_res = 1'b1;
    r.status = err;
  endfunction

  function automatic void go_tail(inout result_t r);
    p_cs = 1'b0;
    p_ph = PH_TAIL;
    tx(r, ByteFill);
  endfunction

  function automatic void start_cmd(inout result_t r, input logic [7:0] c);
    p_cmd = c;
    p_polls = 0;
    p_ph = PH_READY;
    tx(r, ByteFill);
  endfunction

  function automatic logic [7:0] frame_byte(int i);
    case (i)
      0: return p_cmd;
      1: return p_addr[31:24];
      2: return p_addr[23:16];
      3: return p_addr[15:8];
      4: return p_addr[7:0];
      default: return (p_cmd == CmdIdle) ? CrcIdle : ByteFill;
    endcase
  endfunction

  function automatic void on_exchange(inout result_t r, input logic [7:0] miso,
                                      input logic [7:0] wb);
    case (p_ph)
      PH_WAKE: begin
        p_idx++;
        if (p_idx < floor1(lim.wakeup_byte_count)) tx(r, ByteFill);
        else start_cmd(r, CmdIdle);
      end
      PH_READY: begin
        p_polls++;
        if (miso == ByteFill || p_polls >= floor1(lim.ready_poll_limit)) begin
          p_cs = 1'b1;
          p_ph = PH_FRAME;
          p_idx = 0;
          tx(r, frame_byte(0));
        end else tx(r, ByteFill);
      end
      PH_FRAME: begin
        p_idx++;
        if (p_idx < 6) tx(r, frame_byte(p_idx));
        else begin
          p_ph = PH_RESP;
          p_polls = 0;
          tx(r, ByteFill);
        end
      end
      PH_RESP: begin
        p_polls++;
        if (!miso[7] || p_polls >= floor1(lim.response_poll_limit)) begin
          if (p_op == OP_INIT && p_cmd == CmdIdle) begin
            if (miso != 8'h01) end_op(r, 1'b1);
            else begin
              p_rounds = '0;
              p_ph = PH_IDLE_DUMMY;
              tx(r, ByteFill);
            end
          end else if (p_op == OP_INIT) begin
            p_rounds = p_rounds + 16'd1;
            if (miso == 8'h00 || p_rounds >= floor1(lim.idle_exit_limit)) go_tail(r);
            else begin
              p_ph = PH_IDLE_DUMMY;
              tx(r, ByteFill);
            end
          end else if (miso != 8'h00) end_op(r, 1'b1);
          else begin
            p_polls = 0;
            p_ph = (p_op == OP_READ) ? PH_TOKEN : PH_WGAP;
            tx(r, ByteFill);
          end
        end else tx(r, ByteFill);
      end
      PH_IDLE_DUMMY: start_cmd(r, CmdOpcond);
      PH_TOKEN: begin
        p_polls++;
        if (miso == ByteToken || p_polls >= floor1(lim.token_poll_limit)) begin
          p_ph = PH_RDATA;
          p_idx = 0;
        end
        tx(r, ByteFill);
      end
      PH_RDATA: begin
        r.read_byte = miso;
        r.read_valid = 1'b1;
        p_idx++;
        if (p_idx >= BlockBytes) begin
          p_ph = PH_RCRC;
          p_idx = 0;
        end
        tx(r, ByteFill);
      end
      PH_RCRC: begin
        p_idx++;
        if (p_idx < 2) tx(r, ByteFill);
        else go_tail(r);
      end
      PH_WGAP: begin
        p_ph = PH_WTOKEN;
        tx(r, ByteToken);
      end
      PH_WTOKEN: begin
        p_ph = PH_WDATA;
        p_idx = 0;
        tx(r, wb);
        r.write_byte_taken = 1'b1;
      end
      PH_WDATA: begin
        p_idx++;
        if (p_idx < BlockBytes) begin
          tx(r, wb);
          r.write_byte_taken = 1'b1;
        end else begin
          p_ph = PH_WCRC;
          p_idx = 0;
          tx(r, ByteFill);
        end
      end
      PH_WCRC: begin
        p_idx++;
        if (p_idx >= 2) p_ph = PH_WRESP;
        tx(r, ByteFill);
      end
      PH_WRESP: begin
        if ((miso & RespMask) != RespOk) end_op(r, 1'b1);
        else begin
          p_ph = PH_BUSY;
          tx(r, ByteFill);
        end
      end
      PH_BUSY: begin
        if (miso == 8'h00) tx(r, ByteFill);
        else go_tail(r);
      end
      PH_TAIL: end_op(r, 1'b0);
      default: ;
    endcase
  endfunction

  function automatic result_t sequencer_step(item_t it);
    result_t r;
    r = '0;
    r.mosi_byte = ByteFill;
    if (it.action == ACT_INIT) begin
      p_op = OP_INIT;
      p_addr = '0;
      p_cs = 1'b0;
      p_ph = PH_WAKE;
      p_idx = 0;
      tx(r, ByteFill);
    end else if (it.action == ACT_READ || it.action == ACT_WRITE) begin
      p_op = (it.action == ACT_READ) ? OP_READ : OP_WRITE;
      p_addr = it.block_address;
      start_cmd(r, (it.action == ACT_READ) ? CmdRead : CmdWrite);
    end else if (p_ph != PH_IDLE) begin
      on_exchange(r, it.miso_byte, it.write_byte);
    end
    r.chip_select_low = p_cs;
    return r;
  endfunction

  // Card side: answers in the way the predicted phase calls for, with some noise.
  function automatic logic [7:0] card_byte();
    case (p_ph)
      PH_READY: return ($urandom_range(9) < 8) ? ByteFill : 8'($urandom);
      PH_RESP: begin
        case ($urandom_range(19))
          0, 1, 2: return 8'($urandom);
          3, 4, 5: return ByteFill;
          default: begin
            if (p_cmd == CmdIdle) return 8'h01;
            if (p_cmd == CmdOpcond) return ($urandom_range(3) == 0) ? 8'h00 : 8'h01;
            return 8'h00;
          end
        endcase
      end
      PH_TOKEN: begin
        if ($urandom_range(3) == 0) return ByteToken;
        return $urandom_range(1) ? ByteFill : 8'($urandom);
      end
      PH_WRESP: begin
        if ($urandom_range(9) == 0) return 8'($urandom);
        return {3'($urandom), RespOk[4:0]};
      end
      PH_BUSY: return ($urandom_range(2) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    n_bad++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic send_item(input item_t it, input bit typed = 1'b0,
                           input result_t want = '0);
    result_t pred;
    pred = sequencer_step(it);
    if (pred.read_valid) n_rdata++;
    if (pred.write_byte_taken) n_wdata++;
    if (pred.done_res) begin
      n_done++;
      if (pred.status) n_err_ends++;
    end
    expected_q.push_back(typed ? want : pred);
    n_sent++;
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= it.action;
    in_ch.block_address <= it.block_address;
    in_ch.miso_byte     <= it.miso_byte;
    in_ch.write_byte    <= it.write_byte;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic run_op(input action_t act, input bit to_end);
    item_t it;
    int    left;
    it.action = act;
    it.block_address = $urandom;
    it.miso_byte = 8'($urandom);
    it.write_byte = 8'($urandom);
    send_item(it);
    left = to_end ? 1000000 : $urandom_range(1, 40);
    while (left > 0 && p_ph != PH_IDLE) begin
      it.action = ACT_XFER;
      it.block_address = $urandom;
      it.miso_byte = card_byte();
      it.write_byte = 8'($urandom);
      send_item(it);
      left--;
    end
  endtask

  task automatic run_random(input int quota, input bit full_read, input bit full_write);
    item_t it;
    int    first;
    first = n_sent;
    if (full_read) run_op(ACT_READ, 1'b1);
    if (full_write) run_op(ACT_WRITE, 1'b1);
    while (n_sent - first < quota) begin
      if ($urandom_range(9) == 0) begin
        it.action = 2'($urandom);
        it.block_address = $urandom;
        it.miso_byte = 8'($urandom);
        it.write_byte = 8'($urandom);
        send_item(it);
      end else begin
        case ($urandom_range(2))
          0: run_op(ACT_INIT, $urandom_range(1));
          1: run_op(ACT_READ, 1'b0);
          default: run_op(ACT_WRITE, 1'b0);
        endcase
      end
    end
  endtask

  // Wait until every transfer is back, then let the pipeline drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_READY_POLL: lim.ready_poll_limit = val[15:0];
      REG_RESP_POLL:  lim.response_poll_limit = val[7:0];
      REG_IDLE_EXIT:  lim.idle_exit_limit = val[15:0];
      REG_TOKEN_POLL: lim.token_poll_limit = val[15:0];
      default:        lim.wakeup_byte_count = val[7:0];
    endcase
  endtask

  task automatic cfg_all(input int rdy, input int rsp, input int idl, input int tok,
                         input int wk);
    cfg_write(REG_READY_POLL, rdy);
    cfg_write(REG_RESP_POLL, rsp);
    cfg_write(REG_IDLE_EXIT, idl);
    cfg_write(REG_TOKEN_POLL, tok);
    cfg_write(REG_WAKEUP, wk);
  endtask

  function automatic result_t res_of(input logic [7:0] mosi, input logic req,
                                     input logic cs, input logic done, input logic st);
    result_t r;
    r = '0;
    r.mosi_byte = mosi;
    r.exchange_request = req;
    r.chip_select_low = cs;
    r.done_res = done;
    r.status = st;
    return r;
  endfunction

  function automatic dir_row_t row(input action_t a, input logic [31:0] ad,
                                   input logic [7:0] mi, input logic [7:0] wb,
                                   input bit typed = 1'b0, input result_t res = '0);
    dir_row_t d;
    d.it.action = a;
    d.it.block_address = ad;
    d.it.miso_byte = mi;
    d.it.write_byte = wb;
    d.typed = typed;
    d.res = res;
    return d;
  endfunction

  // Long receiver hold-off, counted in cycles.
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 250;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
    end
  end

  // Result checker and ready generator.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          result_t e;
          string   diff;
          e = expected_q.pop_front();
          diff = "";
          if (out_ch.mosi_byte !== e.mosi_byte) diff = {diff, " mosi_byte"};
          if (out_ch.exchange_request !== e.exchange_request)
            diff = {diff, " exchange_request"};
          if (out_ch.chip_select_low !== e.chip_select_low) diff = {diff, " chip_select_low"};
          if (out_ch.read_byte !== e.read_byte) diff = {diff, " read_byte"};
          if (out_ch.read_valid !== e.read_valid) diff = {diff, " read_valid"};
          if (out_ch.write_byte_taken !== e.write_byte_taken)
            diff = {diff, " write_byte_taken"};
          if (out_ch.done_res !== e.done_res) diff = {diff, " done_res"};
          if (out_ch.status !== e.status) diff = {diff, " status"};
          if (diff != "")
            report_mismatch($sformatf("fields%s differ, expected %h", diff, e));
        end
      end
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall);
    end
  end

  initial begin
    #(12 * 3000000);
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_XFER;
    in_ch.block_address = '0;
    in_ch.miso_byte = '0;
    in_ch.write_byte = '0;
    out_ch.ready = 1'b0;
    tx_idle = 0;
    rx_stall = 0;
    hold_req = 1'b0;
    hold_left = 0;
    n_sent = 0;
    n_bad = 0;
    n_rdata = 0;
    n_wdata = 0;
    n_done = 0;
    n_err_ends = 0;
    lim = '{16'd50000, 8'd10, 16'd5000, 16'd10000, 8'd10};
    p_ph = PH_IDLE;
    p_op = OP_INIT;
    p_idx = 0;
    p_polls = 0;
    p_rounds = '0;
    p_addr = '0;
    p_cmd = '0;
    p_cs = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all limits at their minimum so each sequence is short.
    cfg_all(1, 1, 1, 1, 1);
    dir_tab[0]  = row(ACT_XFER, 32'h0, 8'hFF, 8'h00, 1, res_of(ByteFill, 0, 0, 0, 0));
    dir_tab[1]  = row(ACT_INIT, 32'hFFFF_FFFF, 8'h00, 8'hFF, 1,
                      res_of(ByteFill, 1, 0, 0, 0));
    dir_tab[2]  = row(ACT_XFER, 32'h0, 8'h00, 8'h00);
    dir_tab[3]  = row(ACT_XFER, 32'h0, 8'h00, 8'h00, 1, res_of(CmdIdle, 1, 1, 0, 0));
    dir_tab[4]  = row(ACT_XFER, 32'h0, 8'hFF, 8'h00);
    dir_tab[5]  = row(ACT_XFER, 32'h0, 8'hFF, 8'h00);
    dir_tab[6]  = row(ACT_XFER, 32'h0, 8'hFF, 8'h00);
    dir_tab[7]  = row(ACT_XFER, 32'h0, 8'hFF, 8'h00);
    dir_tab[8]  = row(ACT_XFER, 32'h0, 8'hFF, 8'h00, 1, res_of(CrcIdle, 1, 1, 0, 0));
    dir_tab[9]  = row(ACT_XFER, 32'h0, 8'hFF, 8'h00);
    // Idle command answered with something other than the idle response.
    dir_tab[10] = row(ACT_XFER, 32'h0, 8'h05, 8'h00, 1, res_of(ByteFill, 0, 0, 1, 1));
    dir_tab[11] = row(ACT_READ, 32'hFFFF_FFFF, 8'h00, 8'h00, 1,
                      res_of(ByteFill, 1, 0, 0, 0));
    dir_tab[12] = row(ACT_XFER, 32'h0, 8'hFF, 8'h00, 1, res_of(CmdRead, 1, 1, 0, 0));
    dir_tab[13] = row(ACT_XFER, 32'h0, 8'h00, 8'h00);
    dir_tab[14] = row(ACT_XFER, 32'h0, 8'h00, 8'h00);
    dir_tab[15] = row(ACT_XFER, 32'h0, 8'h00, 8'h00);
    dir_tab[16] = row(ACT_XFER, 32'h0, 8'h00, 8'h00);
    dir_tab[17] = row(ACT_XFER, 32'h0, 8'h00, 8'h00);
    dir_tab[18] = row(ACT_XFER, 32'h0, 8'h00, 8'h00);
    // Response poll runs out on a byte with the top bit set: read fails.
    dir_tab[19] = row(ACT_XFER, 32'h0, 8'h80, 8'h00, 1, res_of(ByteFill, 0, 0, 1, 1));
    dir_tab[20] = row(ACT_WRITE, 32'h0, 8'hFF, 8'hFF);
    dir_tab[21] = row(ACT_XFER, 32'h0, 8'hA5, 8'h5A);
    // A new request abandons the write just after its command byte is sent.
    dir_tab[22] = row(ACT_INIT, 32'h1234_5678, 8'h00, 8'h00);
    dir_tab[23] = row(ACT_XFER, 32'h0, 8'h3C, 8'hC3);
    dir_tab[24] = row(ACT_WRITE, 32'h1234_5678, 8'hFF, 8'h00);
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          cfg_all(65535, 255, 65535, 65535, 255);
          tx_idle = 0;
          rx_stall = 0;
        end
        1: begin
          cfg_all(0, 0, 0, 0, 0);
          tx_idle = 58;
          rx_stall = 0;
        end
        2: begin
          cfg_all($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                  $urandom_range(1, 6), $urandom_range(1, 6));
          tx_idle = 0;
          rx_stall = 58;
          hold_req = 1'b1;
        end
        default: begin
          cfg_all(50000, 10, 5000, 10000, 10);
          tx_idle = 14;
          rx_stall = 14;
        end
      endcase
      run_random(30, 1'b0, ph == 3);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Covered %0d transfers: %0d data bytes read, %0d written, %0d operations ended",
             n_sent, n_rdata, n_wdata, n_done);
    $display("Of those endings %0d were errors; four limit settings and four idling mixes",
             n_err_ends);
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sdspi_pkg.sv
rtl/core/sdspi_if.sv
rtl/core/sdspi_front.sv
rtl/core/sdspi_back.sv
rtl/core/sdspi_regs.sv
rtl/core/sd_card_spi_command_sequencer.sv
dv/tb_sd_card_spi_command_sequencer.sv
